FILE: rtl/thc_pkg.sv
// Shared constants, types and coefficient tables for the thermistor converter.
package thc_pkg;

    localparam int ADC_BITS  = 10;
    localparam int FRAC_BITS = 4;
    localparam int LOG_STEPS = 24;
    localparam int LW_W      = LOG_STEPS + 4;
    localparam int ACC_W     = 48;
    localparam int Y_W       = 44;
    localparam int QBITS     = 14;
    localparam int R_W       = Y_W + QBITS;
    localparam int N_W       = 56;

    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [N_W-1:0] SCALE_N = N_W'(64'd1000000000000000 << FRAC_BITS);
    localparam logic signed [15:0] LIM  = 16'(300 << FRAC_BITS);
    localparam logic signed [15:0] KOFF = 16'(273 << FRAC_BITS);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_RAIL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [1:0] SEL_C = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_A = 2'd2;
    localparam logic [1:0] SEL_D = 2'd3;

    typedef struct packed {
        logic       rail;
        logic [1:0] seg;
        logic       force_hi;
    } thc_side_t;

    // Coefficient table in units of 1e-15
    function automatic logic signed [ACC_W-1:0] coef(input logic [1:0] sel,
                                                     input logic [1:0] seg);
        logic signed [63:0] v;
        v = 64'sd0;
        unique case ({sel, seg})
            {SEL_A, 2'd0}: v = 64'sd3357042000000;
            {SEL_A, 2'd1}: v = 64'sd3354017000000;
            {SEL_A, 2'd2}: v = 64'sd3353048100000;
            {SEL_A, 2'd3}: v = 64'sd3353616600000;
            {SEL_B, 2'd0}: v = 64'sd252148480000;
            {SEL_B, 2'd1}: v = 64'sd256172440000;
            {SEL_B, 2'd2}: v = 64'sd254202300000;
            {SEL_B, 2'd3}: v = 64'sd253772000000;
            {SEL_C, 2'd0}: v = 64'sd3374328300;
            {SEL_C, 2'd1}: v = 64'sd2140094300;
            {SEL_C, 2'd2}: v = 64'sd1143116300;
            {SEL_C, 2'd3}: v = 64'sd854332710;
            {SEL_D, 2'd0}: v = -64'sd64957311;
            {SEL_D, 2'd1}: v = -64'sd72405219;
            {SEL_D, 2'd2}: v = -64'sd69383563;
            {SEL_D, 2'd3}: v = -64'sd87912262;
            default:       v = 64'sd0;
        endcase
        return ACC_W'(v);
    endfunction

endpackage

FILE: rtl/thc_sqr_step.sv
// One squaring step of the log2 mantissa pipeline for both operands.
module thc_sqr_step #(
    parameter int BIT_POS = 23
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [30:0]                m_c_in,
    input  logic [30:0]                m_r_in,
    input  logic [thc_pkg::LW_W-1:0]   lw_c_in,
    input  logic [thc_pkg::LW_W-1:0]   lw_r_in,
    output logic [30:0]                m_c_reg,
    output logic [30:0]                m_r_reg,
    output logic [thc_pkg::LW_W-1:0]   lw_c_reg,
    output logic [thc_pkg::LW_W-1:0]   lw_r_reg
);
    import thc_pkg::*;

    logic [61:0] p_c, p_r;
    logic [31:0] s_c, s_r;
    logic [30:0] m_c_next, m_r_next;
    logic [LW_W-1:0] lw_c_next, lw_r_next;

    // Square, truncate, renormalize and emit one fraction bit
    always_comb
    begin
        p_c = {31'b0, m_c_in} * {31'b0, m_c_in};
        p_r = {31'b0, m_r_in} * {31'b0, m_r_in};
        s_c = p_c[61:30];
        s_r = p_r[61:30];
        m_c_next = s_c[31] ? s_c[31:1] : s_c[30:0];
        m_r_next = s_r[31] ? s_r[31:1] : s_r[30:0];
        lw_c_next = lw_c_in | (LW_W'(s_c[31]) << BIT_POS);
        lw_r_next = lw_r_in | (LW_W'(s_r[31]) << BIT_POS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_c_reg  <= m_c_next;
            m_r_reg  <= m_r_next;
            lw_c_reg <= lw_c_next;
            lw_r_reg <= lw_r_next;
        end
    end

endmodule

FILE: rtl/thc_horner_step.sv
// One Horner step, acc*L + coef, as a product stage and an add stage.
module thc_horner_step #(
    parameter logic [1:0] SEL = 2'd0
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [thc_pkg::ACC_W-1:0]  acc_in,
    input  logic [23:0]                       lmag_in,
    input  logic                              lneg_in,
    input  logic [1:0]                        seg_in,
    output logic signed [thc_pkg::ACC_W-1:0]  acc_reg,
    output logic [23:0]                       lmag_reg,
    output logic                              lneg_reg,
    output logic [1:0]                        seg_reg
);
    import thc_pkg::*;

    logic [ACC_W-1:0]    amag;
    logic [ACC_W+23:0]   prod_next, prod_reg;
    logic                pneg_next, pneg_reg;
    logic [23:0]         lmag_mid_reg;
    logic                lneg_mid_reg;
    logic [1:0]          seg_mid_reg;
    logic [ACC_W-1:0]    sh;
    logic signed [ACC_W-1:0] acc_next;

    // Multiply magnitudes, track the product sign
    always_comb
    begin
        amag      = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
        prod_next = {24'b0, amag} * {{ACC_W{1'b0}}, lmag_in};
        pneg_next = acc_in[ACC_W-1] ^ lneg_in;
    end

    // Truncate toward zero, sign and add the next coefficient
    always_comb
    begin
        sh       = ACC_W'(prod_reg >> 20);
        acc_next = (pneg_reg ? -$signed(sh) : $signed(sh)) + coef(SEL, seg_mid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= prod_next;
            pneg_reg     <= pneg_next;
            lmag_mid_reg <= lmag_in;
            lneg_mid_reg <= lneg_in;
            seg_mid_reg  <= seg_in;
            acc_reg      <= acc_next;
            lmag_reg     <= lmag_mid_reg;
            lneg_reg     <= lneg_mid_reg;
            seg_reg      <= seg_mid_reg;
        end
    end

endmodule

FILE: rtl/thc_div_step.sv
// One restoring division step producing a single quotient bit.
module thc_div_step #(
    parameter int SHIFT = 0
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [thc_pkg::R_W-1:0]         r_in,
    input  logic [thc_pkg::Y_W-1:0]         y_in,
    input  logic [thc_pkg::QBITS-1:0]       q_in,
    output logic [thc_pkg::R_W-1:0]         r_reg,
    output logic [thc_pkg::Y_W-1:0]         y_reg,
    output logic [thc_pkg::QBITS-1:0]       q_reg
);
    import thc_pkg::*;

    logic [R_W-1:0]   ys;
    logic             take;
    logic [R_W-1:0]   r_next;
    logic [QBITS-1:0] q_next;

    // Compare and subtract the shifted divisor
    always_comb
    begin
        ys     = R_W'(y_in) << SHIFT;
        take   = (r_in >= ys);
        r_next = take ? r_in - ys : r_in;
        q_next = q_in | (QBITS'(take) << SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            y_reg <= y_in;
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/thermistor_code_to_temperature.sv
// Thermistor divider code to Celsius converter with Steinhart-Hart segments.
// Pipelined from input transaction to result, one stage per register.
// Throughput: one transaction per cycle; 24 log2 squaring stages and 14
// restoring division stages set the depth. The whole pipe holds on output stall.
// Reset: rst_n clears all valid bits asynchronously; payload is not reset.
module thermistor_code_to_temperature (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_code, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [13:0] temperature, [15:14] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import thc_pkg::*;

    localparam int NST = 50;
    localparam int ST_PREP = 33;
    localparam int ST_OVF  = 34;

    logic en;
    logic      valid_reg [0:NST-1];
    thc_side_t side_reg  [0:NST-1];
    thc_side_t side_next [0:NST-1];

    // Front stage signals
    logic [ADC_BITS-1:0] code, rest;
    logic [3:0]  e_c, e_r;
    logic [1:0]  seg;
    logic [31:0] lhs0, rhs0, lhs1, rhs1, lhs2, rhs2;
    logic [30:0] m_c0_reg, m_r0_reg;
    logic [LW_W-1:0] lw_c0_reg, lw_r0_reg;

    logic [30:0]     m_c_s  [1:LOG_STEPS];
    logic [30:0]     m_r_s  [1:LOG_STEPS];
    logic [LW_W-1:0] lw_c_s [1:LOG_STEPS];
    logic [LW_W-1:0] lw_r_s [1:LOG_STEPS];

    logic signed [LW_W:0] diff;
    logic [LW_W-1:0] dmag_reg;
    logic            dneg_reg;
    logic [57:0]     lnprod;
    logic [23:0]     lmag_reg;
    logic            lneg_reg;

    logic signed [ACC_W-1:0] acc_s  [0:3];
    logic [23:0]             lmag_s [0:3];
    logic                    lneg_s [0:3];
    logic [1:0]              seg_s  [0:3];

    logic [Y_W-1:0] y_reg, y34_reg;
    logic [N_W-1:0] n_reg;
    logic           nonpos;
    logic           ovf;
    logic [R_W-1:0] r34_reg;

    logic [R_W-1:0]   r_s [1:QBITS];
    logic [Y_W-1:0]   y_s [1:QBITS];
    logic [QBITS-1:0] q_s [1:QBITS];

    logic signed [15:0] t;
    logic [13:0] temp_next;
    logic [1:0]  stat_next;
    logic [13:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    function automatic logic [3:0] top_bit(input logic [ADC_BITS-1:0] v);
        logic [3:0] e;
        e = 4'd0;
        for (int i = 1; i < ADC_BITS; i++)
        begin
            if (v[i])
            begin
                e = 4'(i);
            end
        end
        return e;
    endfunction

    // Advance the whole pipe unless the result is stalled
    assign en       = m_tready || !valid_reg[NST-1];
    assign s_tready = en;
    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = {2'b00, m_tdata_reg};
    assign m_tuser  = m_tuser_reg;

    // Front: ratio segment, rail check, log2 normalization
    always_comb
    begin
        code = s_tdata[ADC_BITS-1:0];
        rest = FULL - code;
        e_c  = top_bit(code);
        e_r  = top_bit(rest);
        lhs0 = 32'(code) * 32'd1000;
        rhs0 = 32'(rest) * 32'd3277;
        lhs1 = 32'(code) * 32'd10000;
        rhs1 = 32'(rest) * 32'd3599;
        lhs2 = 32'(code) * 32'd100000;
        rhs2 = 32'(rest) * 32'd6816;
        priority if (lhs0 > rhs0)
            seg = 2'd0;
        else if (lhs1 > rhs1)
            seg = 2'd1;
        else if (lhs2 > rhs2)
            seg = 2'd2;
        else
            seg = 2'd3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_c0_reg  <= 31'(code) << (5'd30 - {1'b0, e_c});
            m_r0_reg  <= 31'(rest) << (5'd30 - {1'b0, e_r});
            lw_c0_reg <= {e_c, {LOG_STEPS{1'b0}}};
            lw_r0_reg <= {e_r, {LOG_STEPS{1'b0}}};
        end
    end

    // Log2 fraction pipeline
    generate
        for (genvar k = 1; k <= LOG_STEPS; k++)
        begin : g_sqr
            thc_sqr_step #(.BIT_POS(LOG_STEPS - k)) u_sqr (
                .clk      (clk),
                .en       (en),
                .m_c_in   ((k == 1) ? m_c0_reg  : m_c_s[(k == 1) ? 1 : k - 1]),
                .m_r_in   ((k == 1) ? m_r0_reg  : m_r_s[(k == 1) ? 1 : k - 1]),
                .lw_c_in  ((k == 1) ? lw_c0_reg : lw_c_s[(k == 1) ? 1 : k - 1]),
                .lw_r_in  ((k == 1) ? lw_r0_reg : lw_r_s[(k == 1) ? 1 : k - 1]),
                .m_c_reg  (m_c_s[k]),
                .m_r_reg  (m_r_s[k]),
                .lw_c_reg (lw_c_s[k]),
                .lw_r_reg (lw_r_s[k])
            );
        end
    endgenerate

    // Log difference and conversion to natural log
    always_comb
    begin
        diff   = $signed({1'b0, lw_c_s[LOG_STEPS]}) - $signed({1'b0, lw_r_s[LOG_STEPS]});
        lnprod = {30'b0, dmag_reg} * {28'b0, LN2_Q30};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg <= diff[LW_W] ? LW_W'(-diff) : LW_W'(diff);
            dneg_reg <= diff[LW_W];
            lmag_reg <= lnprod[57:34];
            lneg_reg <= dneg_reg;
        end
    end

    // Horner evaluation of the cubic
    assign acc_s[0]  = coef(SEL_D, side_reg[26].seg);
    assign lmag_s[0] = lmag_reg;
    assign lneg_s[0] = lneg_reg;
    assign seg_s[0]  = side_reg[26].seg;

    thc_horner_step #(.SEL(SEL_C)) u_h0 (
        .clk(clk), .en(en), .acc_in(acc_s[0]), .lmag_in(lmag_s[0]),
        .lneg_in(lneg_s[0]), .seg_in(seg_s[0]), .acc_reg(acc_s[1]),
        .lmag_reg(lmag_s[1]), .lneg_reg(lneg_s[1]), .seg_reg(seg_s[1])
    );
    thc_horner_step #(.SEL(SEL_B)) u_h1 (
        .clk(clk), .en(en), .acc_in(acc_s[1]), .lmag_in(lmag_s[1]),
        .lneg_in(lneg_s[1]), .seg_in(seg_s[1]), .acc_reg(acc_s[2]),
        .lmag_reg(lmag_s[2]), .lneg_reg(lneg_s[2]), .seg_reg(seg_s[2])
    );
    thc_horner_step #(.SEL(SEL_A)) u_h2 (
        .clk(clk), .en(en), .acc_in(acc_s[2]), .lmag_in(lmag_s[2]),
        .lneg_in(lneg_s[2]), .seg_in(seg_s[2]), .acc_reg(acc_s[3]),
        .lmag_reg(lmag_s[3]), .lneg_reg(lneg_s[3]), .seg_reg(seg_s[3])
    );

    // Divider setup: rounded dividend and range check
    assign nonpos = (acc_s[3] <= 0);
    assign ovf    = (R_W'(n_reg) >= (R_W'(y_reg) << QBITS));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg   <= Y_W'(acc_s[3]);
            n_reg   <= SCALE_N + N_W'(Y_W'(acc_s[3]) >> 1);
            y34_reg <= y_reg;
            r34_reg <= R_W'(n_reg);
        end
    end

    // Restoring division, most significant quotient bit first
    generate
        for (genvar k = 1; k <= QBITS; k++)
        begin : g_div
            thc_div_step #(.SHIFT(QBITS - k)) u_div (
                .clk   (clk),
                .en    (en),
                .r_in  ((k == 1) ? r34_reg : r_s[(k == 1) ? 1 : k - 1]),
                .y_in  ((k == 1) ? y34_reg : y_s[(k == 1) ? 1 : k - 1]),
                .q_in  ((k == 1) ? {QBITS{1'b0}} : q_s[(k == 1) ? 1 : k - 1]),
                .r_reg (r_s[k]),
                .y_reg (y_s[k]),
                .q_reg (q_s[k])
            );
        end
    endgenerate

    // Kelvin offset, saturation and status
    always_comb
    begin
        t = $signed({2'b0, q_s[QBITS]}) - KOFF;
        priority if (side_reg[NST-2].rail)
        begin
            temp_next = 14'd0;
            stat_next = ST_RAIL;
        end
        else if (side_reg[NST-2].force_hi || t > LIM)
        begin
            temp_next = 14'(LIM);
            stat_next = ST_SAT;
        end
        else if (t < -LIM)
        begin
            temp_next = 14'(-LIM);
            stat_next = ST_SAT;
        end
        else
        begin
            temp_next = 14'(t);
            stat_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= temp_next;
            m_tuser_reg <= stat_next;
        end
    end

    // Sideband line: rail flag, segment and forced saturation
    always_comb
    begin
        side_next[0].rail     = (code == '0) || (code == FULL);
        side_next[0].seg      = seg;
        side_next[0].force_hi = 1'b0;
        for (int k = 1; k < NST; k++)
        begin
            side_next[k] = side_reg[k-1];
            if (k == ST_PREP)
            begin
                side_next[k].force_hi = nonpos;
            end
            if (k == ST_OVF)
            begin
                side_next[k].force_hi = side_reg[k-1].force_hi | ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NST; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Checks
    a_rail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_RAIL) |-> (m_tdata[13:0] == 14'd0))
        else $error("rail result with nonzero temperature");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |->
        ($signed(m_tdata[13:0]) <= 14'sd4800 && $signed(m_tdata[13:0]) >= -14'sd4800))
        else $error("valid result outside saturation limits");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule
